// File: design/kcd_pkg.sv
package kcd_pkg;

  localparam int KEY_W   = 16;
  localparam int FIELD_W = 16;
  localparam int KIND_W  = 3;
  localparam int STAT_W  = 2;
  localparam int CNT_W   = 5;

  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_REMOVE     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SEARCH     = 3'd4;
  localparam logic [KIND_W-1:0] KIND_NEXT       = 3'd5;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

endpackage

// File: design/kcd_entry_ram.sv
module kcd_entry_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 48
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/kcd_walk_unit.sv
module kcd_walk_unit #(
  parameter int CAPACITY = 16,
  parameter int IW       = 4,
  parameter int CW       = 5
) (
  input  logic [IW-1:0]              front,
  input  logic [CW-1:0]              pos,
  input  logic [kcd_pkg::KEY_W-1:0]  key_ref,
  input  logic [kcd_pkg::KEY_W-1:0]  key_cmp,
  output logic [IW-1:0]              slot,
  output logic                       hit
);

  logic [CW:0] sum;
  logic [CW:0] wrapped;

  // Logical position to physical slot: one add and one conditional subtract.
  always_comb begin
    sum     = (CW + 1)'(front) + (CW + 1)'(pos);
    wrapped = (sum >= (CW + 1)'(CAPACITY)) ? sum - (CW + 1)'(CAPACITY) : sum;
    slot    = wrapped[IW-1:0];
  end

  assign hit = (key_ref == key_cmp);

endmodule

// File: design/kcd_seq.sv
module kcd_seq #(
  parameter int CAPACITY = 16,
  parameter int TW       = 16,
  parameter int IW       = 4,
  parameter int CW       = 5,
  parameter int EW       = 48
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [kcd_pkg::KIND_W-1:0]  in_kind,
  input  logic [kcd_pkg::KEY_W-1:0]   in_key,
  input  logic [kcd_pkg::FIELD_W-1:0] in_name,
  input  logic [kcd_pkg::FIELD_W-1:0] in_ride,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [kcd_pkg::STAT_W-1:0]  out_status,
  output logic [kcd_pkg::KEY_W-1:0]   out_key,
  output logic [kcd_pkg::FIELD_W-1:0] out_name,
  output logic [kcd_pkg::FIELD_W-1:0] out_ride,
  output logic [kcd_pkg::CNT_W-1:0]   out_count,
  output logic [IW-1:0]               walk_front,
  output logic [CW-1:0]               walk_pos,
  output logic [kcd_pkg::KEY_W-1:0]   walk_key_ref,
  output logic [kcd_pkg::KEY_W-1:0]   walk_key_cmp,
  input  logic [IW-1:0]               walk_slot,
  input  logic                        walk_hit,
  output logic                        ram_we,
  output logic [IW-1:0]               ram_waddr,
  output logic [EW-1:0]               ram_wdata,
  output logic                        ram_re,
  output logic [IW-1:0]               ram_raddr,
  input  logic [EW-1:0]               ram_rdata
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DEC   = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_NREAD = 3'd4;
  localparam logic [2:0] S_RESP  = 3'd5;

  localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
  localparam logic [IW-1:0] LAST_C = IW'(CAPACITY - 1);

  logic [2:0]                   state_r, state_nxt;
  logic [IW-1:0]                front_r, front_nxt;
  logic [CW-1:0]                count_r, count_nxt;
  logic [kcd_pkg::KIND_W-1:0]   kind_r, kind_nxt;
  logic [kcd_pkg::KEY_W-1:0]    key_r, key_nxt;
  logic [TW-1:0]                name_r, name_nxt;
  logic [TW-1:0]                ride_r, ride_nxt;
  logic [CW-1:0]                scan_p_r, scan_p_nxt;
  logic                         cmp_v_r, cmp_v_nxt;
  logic [CW-1:0]                cmp_p_r, cmp_p_nxt;
  logic [IW-1:0]                cmp_addr_r, cmp_addr_nxt;
  logic [IW-1:0]                dst_r, dst_nxt;
  logic [IW-1:0]                src_r, src_nxt;
  logic                         sv_r, sv_nxt;
  logic [kcd_pkg::STAT_W-1:0]   res_status_r, res_status_nxt;
  logic [kcd_pkg::KEY_W-1:0]    res_key_r, res_key_nxt;
  logic [kcd_pkg::FIELD_W-1:0]  res_name_r, res_name_nxt;
  logic [kcd_pkg::FIELD_W-1:0]  res_ride_r, res_ride_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [kcd_pkg::STAT_W-1:0]   out_status_r, out_status_nxt;
  logic [kcd_pkg::KEY_W-1:0]    out_key_r, out_key_nxt;
  logic [kcd_pkg::FIELD_W-1:0]  out_name_r, out_name_nxt;
  logic [kcd_pkg::FIELD_W-1:0]  out_ride_r, out_ride_nxt;
  logic [kcd_pkg::CNT_W-1:0]    out_count_r, out_count_nxt;

  logic [kcd_pkg::KEY_W-1:0]    rd_key;
  logic [kcd_pkg::FIELD_W-1:0]  rd_name;
  logic [kcd_pkg::FIELD_W-1:0]  rd_ride;
  logic [CW-1:0]                next_p;
  logic [IW-1:0]                front_dec;
  logic [IW-1:0]                front_inc;
  logic                         matched;

  assign rd_key  = ram_rdata[EW-1 -: kcd_pkg::KEY_W];
  assign rd_name = kcd_pkg::FIELD_W'(ram_rdata[2*TW-1:TW]);
  assign rd_ride = kcd_pkg::FIELD_W'(ram_rdata[TW-1:0]);

  assign walk_front   = front_r;
  assign walk_key_ref = key_r;
  assign walk_key_cmp = rd_key;
  assign matched      = cmp_v_r && walk_hit;

  assign next_p    = (cmp_p_r + CW'(1) == count_r) ? '0 : cmp_p_r + CW'(1);
  assign front_dec = (front_r == '0) ? LAST_C : front_r - IW'(1);
  assign front_inc = (front_r == LAST_C) ? '0 : front_r + IW'(1);

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_key    = out_key_r;
  assign out_name   = out_name_r;
  assign out_ride   = out_ride_r;
  assign out_count  = out_count_r;

  always_comb begin
    state_nxt      = state_r;
    front_nxt      = front_r;
    count_nxt      = count_r;
    kind_nxt       = kind_r;
    key_nxt        = key_r;
    name_nxt       = name_r;
    ride_nxt       = ride_r;
    scan_p_nxt     = scan_p_r;
    cmp_v_nxt      = cmp_v_r;
    cmp_p_nxt      = cmp_p_r;
    cmp_addr_nxt   = cmp_addr_r;
    dst_nxt        = dst_r;
    src_nxt        = src_r;
    sv_nxt         = sv_r;
    res_status_nxt = res_status_r;
    res_key_nxt    = res_key_r;
    res_name_nxt   = res_name_r;
    res_ride_nxt   = res_ride_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_key_nxt    = out_key_r;
    out_name_nxt   = out_name_r;
    out_ride_nxt   = out_ride_r;
    out_count_nxt  = out_count_r;
    walk_pos       = scan_p_r;
    ram_we         = 1'b0;
    ram_waddr      = walk_slot;
    ram_wdata      = {key_r, name_r, ride_r};
    ram_re         = 1'b0;
    ram_raddr      = walk_slot;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt  = in_kind;
          key_nxt   = in_key;
          name_nxt  = in_name[TW-1:0];
          ride_nxt  = in_ride[TW-1:0];
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        res_status_nxt = kcd_pkg::ST_DONE;
        res_key_nxt    = '0;
        res_name_nxt   = '0;
        res_ride_nxt   = '0;
        state_nxt      = S_RESP;
        case (kind_r)
          kcd_pkg::KIND_PUSH_BACK: begin
            if (count_r == CAP_C) begin
              res_status_nxt = kcd_pkg::ST_FULL;
            end else begin
              walk_pos  = count_r;
              ram_we    = 1'b1;
              ram_waddr = walk_slot;
              count_nxt = count_r + CW'(1);
            end
          end
          kcd_pkg::KIND_PUSH_FRONT: begin
            if (count_r == CAP_C) begin
              res_status_nxt = kcd_pkg::ST_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = front_dec;
              front_nxt = front_dec;
              count_nxt = count_r + CW'(1);
            end
          end
          kcd_pkg::KIND_POP_FRONT: begin
            if (count_r == '0) begin
              res_status_nxt = kcd_pkg::ST_EMPTY;
            end else begin
              front_nxt = front_inc;
              count_nxt = count_r - CW'(1);
            end
          end
          kcd_pkg::KIND_REMOVE, kcd_pkg::KIND_SEARCH, kcd_pkg::KIND_NEXT: begin
            if (count_r == '0) begin
              res_status_nxt = kcd_pkg::ST_EMPTY;
            end else begin
              scan_p_nxt = '0;
              cmp_v_nxt  = 1'b0;
              state_nxt  = S_SCAN;
            end
          end
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        // Reads are issued one entry ahead of the key compare.
        if (matched) begin
          cmp_v_nxt = 1'b0;
          case (kind_r)
            kcd_pkg::KIND_SEARCH: begin
              res_key_nxt  = rd_key;
              res_name_nxt = rd_name;
              res_ride_nxt = rd_ride;
              state_nxt    = S_RESP;
            end
            kcd_pkg::KIND_NEXT: begin
              walk_pos  = next_p;
              ram_re    = 1'b1;
              ram_raddr = walk_slot;
              state_nxt = S_NREAD;
            end
            default: begin
              dst_nxt    = cmp_addr_r;
              scan_p_nxt = cmp_p_r + CW'(1);
              sv_nxt     = 1'b0;
              state_nxt  = S_SHIFT;
            end
          endcase
        end else if (scan_p_r < count_r) begin
          walk_pos     = scan_p_r;
          ram_re       = 1'b1;
          ram_raddr    = walk_slot;
          cmp_v_nxt    = 1'b1;
          cmp_p_nxt    = scan_p_r;
          cmp_addr_nxt = walk_slot;
          scan_p_nxt   = scan_p_r + CW'(1);
        end else begin
          cmp_v_nxt = 1'b0;
          if (!cmp_v_r) begin
            res_status_nxt = kcd_pkg::ST_MISS;
            state_nxt      = S_RESP;
          end
        end
      end
      S_SHIFT: begin
        // Each later entry moves one place toward the front.
        if (sv_r) begin
          ram_we    = 1'b1;
          ram_waddr = dst_r;
          ram_wdata = ram_rdata;
          dst_nxt   = src_r;
        end
        if (scan_p_r < count_r) begin
          walk_pos   = scan_p_r;
          ram_re     = 1'b1;
          ram_raddr  = walk_slot;
          src_nxt    = walk_slot;
          sv_nxt     = 1'b1;
          scan_p_nxt = scan_p_r + CW'(1);
        end else begin
          sv_nxt = 1'b0;
          if (!sv_r) begin
            count_nxt = count_r - CW'(1);
            state_nxt = S_RESP;
          end
        end
      end
      S_NREAD: begin
        res_key_nxt  = rd_key;
        res_name_nxt = rd_name;
        res_ride_nxt = rd_ride;
        state_nxt    = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_key_nxt    = res_key_r;
          out_name_nxt   = res_name_r;
          out_ride_nxt   = res_ride_r;
          out_count_nxt  = kcd_pkg::CNT_W'(count_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      cmp_v_r     <= 1'b0;
      sv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      cmp_v_r     <= cmp_v_nxt;
      sv_r        <= sv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    key_r        <= key_nxt;
    name_r       <= name_nxt;
    ride_r       <= ride_nxt;
    scan_p_r     <= scan_p_nxt;
    cmp_p_r      <= cmp_p_nxt;
    cmp_addr_r   <= cmp_addr_nxt;
    dst_r        <= dst_nxt;
    src_r        <= src_nxt;
    res_status_r <= res_status_nxt;
    res_key_r    <= res_key_nxt;
    res_name_r   <= res_name_nxt;
    res_ride_r   <= res_ride_nxt;
    out_status_r <= out_status_nxt;
    out_key_r    <= out_key_nxt;
    out_name_r   <= out_name_nxt;
    out_ride_r   <= out_ride_nxt;
    out_count_r  <= out_count_nxt;
  end

endmodule

// File: design/keyed_circular_deque_unit.sv
// Push, pop, empty and ignored requests go through decode and the response state only.
// Search and next scan from the front to the match; next then reads the entry after it, wrapping.
// Remove scans to the match, then shifts every later entry toward the front; a miss scans all N entries.
// Throughput: one request at a time; in_tready returns in the same cycle a result is presented.
// Reset (rst_n low, synchronous) empties the ring; the entry RAM itself is not cleared.
module keyed_circular_deque_unit #(
  parameter int CAPACITY = 16,
  parameter int TAG_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,  // key[15:0], name_tag[31:16], ride_tag[47:32]
  input  logic [2:0]  in_tuser,  // kind[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata, // found_key, found_name, found_ride, entry_count, zero fill
  output logic [1:0]  out_tuser  // status[1:0]
);

  localparam int TW = (TAG_BITS < kcd_pkg::FIELD_W) ? TAG_BITS : kcd_pkg::FIELD_W;
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = kcd_pkg::KEY_W + 2 * TW;

  logic [kcd_pkg::STAT_W-1:0]  res_status;
  logic [kcd_pkg::KEY_W-1:0]   res_key;
  logic [kcd_pkg::FIELD_W-1:0] res_name;
  logic [kcd_pkg::FIELD_W-1:0] res_ride;
  logic [kcd_pkg::CNT_W-1:0]   res_count;
  logic [IW-1:0]               walk_front;
  logic [CW-1:0]               walk_pos;
  logic [kcd_pkg::KEY_W-1:0]   walk_key_ref;
  logic [kcd_pkg::KEY_W-1:0]   walk_key_cmp;
  logic [IW-1:0]               walk_slot;
  logic                        walk_hit;
  logic                        ram_we;
  logic [IW-1:0]               ram_waddr;
  logic [EW-1:0]               ram_wdata;
  logic                        ram_re;
  logic [IW-1:0]               ram_raddr;
  logic [EW-1:0]               ram_rdata;

  kcd_entry_ram #(
    .DEPTH(CAPACITY),
    .AW   (IW),
    .DW   (EW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  kcd_walk_unit #(
    .CAPACITY(CAPACITY),
    .IW      (IW),
    .CW      (CW)
  ) u_walk (
    .front  (walk_front),
    .pos    (walk_pos),
    .key_ref(walk_key_ref),
    .key_cmp(walk_key_cmp),
    .slot   (walk_slot),
    .hit    (walk_hit)
  );

  kcd_seq #(
    .CAPACITY(CAPACITY),
    .TW      (TW),
    .IW      (IW),
    .CW      (CW),
    .EW      (EW)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_kind     (in_tuser),
    .in_key      (in_tdata[15:0]),
    .in_name     (in_tdata[31:16]),
    .in_ride     (in_tdata[47:32]),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_status  (res_status),
    .out_key     (res_key),
    .out_name    (res_name),
    .out_ride    (res_ride),
    .out_count   (res_count),
    .walk_front  (walk_front),
    .walk_pos    (walk_pos),
    .walk_key_ref(walk_key_ref),
    .walk_key_cmp(walk_key_cmp),
    .walk_slot   (walk_slot),
    .walk_hit    (walk_hit),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata)
  );

  assign out_tdata = {3'b000, res_count, res_ride, res_name, res_key};
  assign out_tuser = res_status;

endmodule

// File: tb/keyed_circular_deque_checker.sv
`timescale 1ns / 100ps

module keyed_circular_deque_checker #(
  parameter int CAPACITY = 16,
  parameter int TAG_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,  // key[15:0], name_tag[31:16], ride_tag[47:32]
  input  logic [2:0]  in_tuser,  // kind[2:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [55:0] out_tdata, // found_key, found_name, found_ride, entry_count, zero fill
  input  logic [1:0]  out_tuser, // status[1:0]
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic [kcd_pkg::STAT_W-1:0]  status;
    logic [kcd_pkg::KEY_W-1:0]   key;
    logic [kcd_pkg::FIELD_W-1:0] name;
    logic [kcd_pkg::FIELD_W-1:0] ride;
    logic [kcd_pkg::CNT_W-1:0]   count;
  } ring_reply_t;

  logic [kcd_pkg::KEY_W-1:0]   ring_key  [CAPACITY];
  logic [kcd_pkg::FIELD_W-1:0] ring_name [CAPACITY];
  logic [kcd_pkg::FIELD_W-1:0] ring_ride [CAPACITY];
  int unsigned                 head;
  logic [kcd_pkg::CNT_W-1:0]   fill;
  ring_reply_t                 expected_replies[$];

  localparam longint unsigned TAG_MASK = (64'd1 << TAG_BITS) - 64'd1;

  function automatic int unsigned slot_at(int unsigned pos);
    return (head + pos) % CAPACITY;
  endfunction

  function automatic int unsigned find_first(logic [kcd_pkg::KEY_W-1:0] key);
    int unsigned p;
    p = 0;
    while (p < fill && ring_key[slot_at(p)] != key) p++;
    return p;
  endfunction

  function automatic void store_entry(int unsigned s, logic [kcd_pkg::KEY_W-1:0] key,
                                      logic [kcd_pkg::FIELD_W-1:0] name,
                                      logic [kcd_pkg::FIELD_W-1:0] ride);
    ring_key[s]  = key;
    ring_name[s] = name & kcd_pkg::FIELD_W'(TAG_MASK);
    ring_ride[s] = ride & kcd_pkg::FIELD_W'(TAG_MASK);
  endfunction

  // Applies one request to the ring and returns the reply it must produce.
  function automatic ring_reply_t ring_apply(logic [kcd_pkg::KIND_W-1:0] kind,
                                             logic [kcd_pkg::KEY_W-1:0] key,
                                             logic [kcd_pkg::FIELD_W-1:0] name,
                                             logic [kcd_pkg::FIELD_W-1:0] ride);
    ring_reply_t r;
    int unsigned p;
    int unsigned s;
    r = '0;
    r.status = kcd_pkg::ST_DONE;
    case (kind)
      kcd_pkg::KIND_PUSH_BACK, kcd_pkg::KIND_PUSH_FRONT: begin
        if (fill >= CAPACITY) begin
          r.status = kcd_pkg::ST_FULL;
        end else begin
          if (kind == kcd_pkg::KIND_PUSH_FRONT) begin
            head = (head + CAPACITY - 1) % CAPACITY;
            s = head;
          end else begin
            s = slot_at(fill);
          end
          store_entry(s, key, name, ride);
          fill++;
        end
      end
      kcd_pkg::KIND_POP_FRONT: begin
        if (fill == 0) begin
          r.status = kcd_pkg::ST_EMPTY;
        end else begin
          head = (head + 1) % CAPACITY;
          fill--;
        end
      end
      kcd_pkg::KIND_REMOVE: begin
        if (fill == 0) begin
          r.status = kcd_pkg::ST_EMPTY;
        end else begin
          p = find_first(key);
          if (p >= fill) begin
            r.status = kcd_pkg::ST_MISS;
          end else begin
            for (; p + 1 < fill; p++) begin
              ring_key[slot_at(p)]  = ring_key[slot_at(p + 1)];
              ring_name[slot_at(p)] = ring_name[slot_at(p + 1)];
              ring_ride[slot_at(p)] = ring_ride[slot_at(p + 1)];
            end
            fill--;
          end
        end
      end
      kcd_pkg::KIND_SEARCH, kcd_pkg::KIND_NEXT: begin
        if (fill == 0) begin
          r.status = kcd_pkg::ST_EMPTY;
        end else begin
          p = find_first(key);
          if (p >= fill) begin
            r.status = kcd_pkg::ST_MISS;
          end else begin
            if (kind == kcd_pkg::KIND_NEXT) p = (p + 1) % fill;
            s = slot_at(p);
            r.key  = ring_key[s];
            r.name = ring_name[s];
            r.ride = ring_ride[s];
          end
        end
      end
      default: ;
    endcase
    r.count = fill;
    return r;
  endfunction

  always @(posedge clk) begin
    ring_reply_t want;
    if (!rst_n) begin
      head = 0;
      fill = '0;
      expected_replies.delete();
      errors = 0;
    end else begin
      if (in_tvalid && in_tready)
        expected_replies.push_back(ring_apply(in_tuser, in_tdata[15:0], in_tdata[31:16],
                                              in_tdata[47:32]));
      if (out_tvalid && out_tready) begin
        if (expected_replies.size() == 0) begin
          $error("reply with no request outstanding: status %0d, data %h",
                 out_tuser, out_tdata);
          errors++;
        end else begin
          want = expected_replies.pop_front();
          if (out_tuser !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_tuser);
            errors++;
          end
          if (out_tdata[15:0] !== want.key) begin
            $error("found_key: expected %h, got %h", want.key, out_tdata[15:0]);
            errors++;
          end
          if (out_tdata[31:16] !== want.name) begin
            $error("found_name: expected %h, got %h", want.name, out_tdata[31:16]);
            errors++;
          end
          if (out_tdata[47:32] !== want.ride) begin
            $error("found_ride: expected %h, got %h", want.ride, out_tdata[47:32]);
            errors++;
          end
          if (out_tdata[52:48] !== want.count) begin
            $error("entry_count: expected %0d, got %0d", want.count, out_tdata[52:48]);
            errors++;
          end
        end
      end
    end
    pending = expected_replies.size();
  end

endmodule

// File: tb/keyed_circular_deque_unit_tb.sv
`timescale 1ns / 100ps

module keyed_circular_deque_unit_tb;

  localparam int CAPACITY     = 16;
  localparam int TAG_BITS     = 16;
  localparam int STALL_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 60;

  // Kinds the block has no operation for; it must ignore them.
  localparam logic [kcd_pkg::KIND_W-1:0] KIND_SPARE_LO = 3'd6;
  localparam logic [kcd_pkg::KIND_W-1:0] KIND_SPARE_HI = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic [1:0]  out_tuser;

  int                        errors;
  int                        pending;
  int                        send_idle_pct = 0;
  int                        recv_idle_pct = 0;
  bit                        hold_req = 1'b0;
  int                        quiet_cycles = 0;
  bit                        drain_mode = 1'b0;
  logic [kcd_pkg::KEY_W-1:0] key_pool [8];

  always #5 clk = ~clk;

  keyed_circular_deque_unit #(
    .CAPACITY(CAPACITY),
    .TAG_BITS(TAG_BITS)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  keyed_circular_deque_checker #(
    .CAPACITY(CAPACITY),
    .TAG_BITS(TAG_BITS)
  ) u_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .errors(errors),
    .pending(pending)
  );

  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_request(input logic [kcd_pkg::KIND_W-1:0] kind,
                              input logic [kcd_pkg::KEY_W-1:0] key,
                              input logic [kcd_pkg::FIELD_W-1:0] name,
                              input logic [kcd_pkg::FIELD_W-1:0] ride);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {ride, name, key};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic refresh_pool();
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < 8; i++) key_pool[i] = kcd_pkg::KEY_W'($urandom());
  endtask

  task automatic wait_all_replies();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // Traffic mostly on a small key pool so that lookups hit, with a few spare kinds mixed in and the mix leaning
  // toward pushes or toward removals in turn so the count sweeps from empty to full.
  task automatic send_random(input int count);
    logic [kcd_pkg::KIND_W-1:0]  kind;
    logic [kcd_pkg::KEY_W-1:0]   key;
    logic [kcd_pkg::FIELD_W-1:0] name;
    logic [kcd_pkg::FIELD_W-1:0] ride;
    int                          r;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 5) drain_mode = !drain_mode;
      if ($urandom_range(99) < 2) refresh_pool();
      r = $urandom_range(99);
      if (r < 3) begin
        kind = $urandom_range(1) ? KIND_SPARE_HI : KIND_SPARE_LO;
      end else begin
        r = $urandom_range(99);
        if (r < (drain_mode ? 33 : 58))
          kind = $urandom_range(1) ? kcd_pkg::KIND_PUSH_FRONT : kcd_pkg::KIND_PUSH_BACK;
        else if (r < (drain_mode ? 55 : 66))
          kind = kcd_pkg::KIND_POP_FRONT;
        else if (r < (drain_mode ? 75 : 74))
          kind = kcd_pkg::KIND_REMOVE;
        else if (r < 87)
          kind = kcd_pkg::KIND_SEARCH;
        else
          kind = kcd_pkg::KIND_NEXT;
      end
      if ($urandom_range(99) < 85) key = key_pool[$urandom_range(7)];
      else key = kcd_pkg::KEY_W'($urandom());
      name = kcd_pkg::FIELD_W'($urandom());
      ride = kcd_pkg::FIELD_W'($urandom());
      send_request(kind, key, name, ride);
    end
  endtask

  initial begin
    refresh_pool();
    send_idle_pct = 29;
    recv_idle_pct = 87;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_request(kcd_pkg::KIND_POP_FRONT, 16'h0000, 16'h0000, 16'h0000);
    send_request(kcd_pkg::KIND_REMOVE, 16'h0000, 16'h0000, 16'h0000);
    send_request(kcd_pkg::KIND_SEARCH, 16'hFFFF, 16'h0000, 16'h0000);
    send_request(kcd_pkg::KIND_NEXT, 16'h0000, 16'h0000, 16'h0000);
    send_request(KIND_SPARE_LO, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_request(KIND_SPARE_HI, 16'h5A5A, 16'hA5A5, 16'h0F0F);
    send_request(kcd_pkg::KIND_PUSH_BACK, 16'h0000, 16'h0000, 16'h0000);
    send_request(kcd_pkg::KIND_NEXT, 16'h0000, 16'h0000, 16'h0000);
    send_request(kcd_pkg::KIND_PUSH_FRONT, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_request(kcd_pkg::KIND_PUSH_BACK, 16'h0000, 16'h1234, 16'h5678);
    send_request(kcd_pkg::KIND_SEARCH, 16'h0000, 16'h0000, 16'h0000);
    send_request(kcd_pkg::KIND_NEXT, 16'h0000, 16'h0000, 16'h0000);
    send_request(kcd_pkg::KIND_PUSH_BACK, 16'h0007, 16'hAAAA, 16'h5555);
    send_request(kcd_pkg::KIND_NEXT, 16'h0007, 16'h0000, 16'h0000);
    send_request(kcd_pkg::KIND_REMOVE, 16'h1234, 16'h0000, 16'h0000);
    send_request(kcd_pkg::KIND_REMOVE, 16'h0000, 16'h0000, 16'h0000);
    send_request(kcd_pkg::KIND_POP_FRONT, 16'h0000, 16'h0000, 16'h0000);
    for (int i = 0; i < 15; i++)
      send_request(kcd_pkg::KIND_PUSH_BACK, kcd_pkg::KEY_W'(i * 16'h1111),
                   kcd_pkg::FIELD_W'($urandom()), kcd_pkg::FIELD_W'($urandom()));
    send_request(kcd_pkg::KIND_REMOVE, 16'hDDDD, 16'h0000, 16'h0000);

    send_random(250);
    hold_req = 1'b1;
    send_random(20);
    wait_all_replies();
    send_random(250);

    send_idle_pct = 87;
    recv_idle_pct = 29;
    send_random(530);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(530);

    wait_all_replies();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
